// File: sv/gbk_pkg.sv
// shared types and constants of the grid bucketed keypoint selector
// no dependencies
package gbk_pkg;
   localparam int IDX_W     = 12;  // kept index width
   localparam int KEY_W     = 32;  // strength with sign bit flipped
   localparam int ENT_W     = IDX_W + KEY_W;
   localparam int DIM_W     = 13;
   localparam int CS_W      = 11;
   localparam int GRID_W    = 14;  // grid columns, rows and divider width
   localparam int CELLS_W   = 28;
   localparam int OP_CELL_W = 14;
   localparam int OP_PER_W  = 7;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_CELL_SIZE,
      CSR_TARGET_FEATURES
   } csr_index_type;

   typedef struct packed {
      logic                 kind;
      logic [OP_CELL_W-1:0] bucket;
      logic [OP_PER_W-1:0]  per;
      logic [KEY_W-1:0]     key;
   } gbk_op_type;

   localparam int OP_W = $bits(gbk_op_type);

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_GEOM_START,
      FS_GEOM_WAIT,
      FS_CELLS,
      FS_PER,
      FS_DIV_WAIT,
      FS_MUL,
      FS_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_L_CNT,
      BS_L_SCAN,
      BS_L_CMP,
      BS_L_DONE,
      BS_D_RD,
      BS_D_CHK,
      BS_D_ENT,
      BS_EMIT
   } back_state_type;
endpackage

// File: sv/gbk_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module gbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/gbk_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module gbk_div #(
   parameter int W = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in, d_ff, d_in;
   logic [W:0]    rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    shifted;
   logic          ge;

   always_comb begin
      shifted = {rem_ff[W-1:0], q_ff[W-1]};
      ge      = shifted >= {1'b0, d_ff};
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         d_in    = divisor;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, d_ff} : shifted;
         q_in   = {q_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// File: sv/gbk_queue.sv
// small register queue between the front and back parts
// no dependencies
module gbk_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      in_ready  = cnt_ff != CW'(DEPTH);
      out_valid = cnt_ff != '0;
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wp_in     = push ? (wp_ff == PW'(DEPTH - 1) ? '0 : wp_ff + PW'(1)) : wp_ff;
      rp_in     = pop ? (rp_ff == PW'(DEPTH - 1) ? '0 : rp_ff + PW'(1)) : rp_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(pop);
      out_data  = slot_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// File: sv/gbk_front.sv
// front part: grid geometry, item accept, cell classification
// depends on gbk_pkg and gbk_div
module gbk_front import gbk_pkg::*; #(
   parameter int MAX_CELLS    = 1024,
   parameter int MAX_PER_CELL = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] image_width,
   input  logic [DIM_W-1:0] image_height,
   input  logic [CS_W-1:0]  cell_size,
   input  logic [DIM_W-1:0] target_features,
   input  logic             csr_we,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,
   input  logic             req_tuser,
   output logic             op_valid,
   input  logic             op_ready,
   output gbk_op_type       op
);
   localparam int PER_W = $clog2(MAX_PER_CELL + 1);

   front_state_type      state_ff, state_in;
   logic                 dirty_ff, dirty_in;
   logic [GRID_W-1:0]    gcols_ff, gcols_in, grows_ff, grows_in;
   logic [GRID_W-1:0]    gx_ff, gx_in, gy_ff, gy_in;
   logic [CELLS_W-1:0]   cells_ff, cells_in, cell_ff, cell_in;
   logic [PER_W-1:0]     per_ff, per_in, per_cnt;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 kind_ff, kind_in;
   logic [CS_W-1:0]      cs1;
   logic [DIM_W-1:0]     w1, h1;
   logic                 div_start, done_x, done_y;
   logic [GRID_W-1:0]    dvd_x, dvd_y, dvs, q_x, q_y;
   logic [CELLS_W-1:0]   cell_clamp;

   gbk_div #(.W(GRID_W)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_x),
      .divisor(dvs), .done(done_x), .quotient(q_x)
   );
   gbk_div #(.W(GRID_W)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_y),
      .divisor(dvs), .done(done_y), .quotient(q_y)
   );

   always_comb begin
      cs1 = (cell_size == '0) ? CS_W'(1) : cell_size;
      w1  = (image_width == '0) ? DIM_W'(1) : image_width;
      h1  = (image_height == '0) ? DIM_W'(1) : image_height;
      dvs = GRID_W'(cs1);
      if (state_ff == FS_GEOM_START) begin
         dvd_x = GRID_W'(w1) + GRID_W'(cs1) - GRID_W'(1);
         dvd_y = GRID_W'(h1) + GRID_W'(cs1) - GRID_W'(1);
      end else begin
         dvd_x = GRID_W'(req_tdata[15:4]);
         dvd_y = GRID_W'(req_tdata[31:20]);
      end
      // per cell share: count of multiples of the cell count within target, up to MAX_PER_CELL
      per_cnt = '0;
      for (int p = 1; p <= MAX_PER_CELL; p++) begin
         if ({7'd0, cells_ff} * (CELLS_W + 7)'(p) <= (CELLS_W + 7)'(target_features)) begin
            per_cnt = per_cnt + PER_W'(1);
         end
      end
      cell_clamp = (cell_ff >= CELLS_W'(MAX_CELLS)) ? CELLS_W'(MAX_CELLS - 1) : cell_ff;
   end

   always_comb begin
      state_in   = state_ff;
      dirty_in   = csr_we ? 1'b1 : dirty_ff;
      gcols_in   = gcols_ff;
      grows_in   = grows_ff;
      gx_in      = gx_ff;
      gy_in      = gy_ff;
      cells_in   = cells_ff;
      cell_in    = cell_ff;
      per_in     = per_ff;
      key_in     = key_ff;
      kind_in    = kind_ff;
      div_start  = 1'b0;
      req_tready = 1'b0;
      op_valid   = 1'b0;
      case (state_ff)
         FS_IDLE: begin
            req_tready = !dirty_ff;
            if (dirty_ff) begin
               state_in = FS_GEOM_START;
            end else if (req_tvalid) begin
               kind_in = req_tuser;
               key_in  = req_tdata[63:32] ^ 32'h8000_0000;
               if (req_tuser == KIND_DRAIN) begin
                  state_in = FS_PUSH;
               end else begin
                  div_start = 1'b1;
                  state_in  = FS_DIV_WAIT;
               end
            end
         end
         FS_GEOM_START: begin
            div_start = 1'b1;
            dirty_in  = csr_we;
            state_in  = FS_GEOM_WAIT;
         end
         FS_GEOM_WAIT: begin
            if (done_x && done_y) begin
               gcols_in = q_x;
               grows_in = q_y;
               state_in = FS_CELLS;
            end
         end
         FS_CELLS: begin
            cells_in = CELLS_W'(gcols_ff) * CELLS_W'(grows_ff);
            state_in = FS_PER;
         end
         FS_PER: begin
            per_in   = (per_cnt == '0) ? PER_W'(1) : per_cnt;
            state_in = FS_IDLE;
         end
         FS_DIV_WAIT: begin
            if (done_x && done_y) begin
               gx_in    = (q_x > gcols_ff - GRID_W'(1)) ? gcols_ff - GRID_W'(1) : q_x;
               gy_in    = (q_y > grows_ff - GRID_W'(1)) ? grows_ff - GRID_W'(1) : q_y;
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            cell_in  = CELLS_W'(gy_ff) * CELLS_W'(gcols_ff) + CELLS_W'(gx_ff);
            state_in = FS_PUSH;
         end
         FS_PUSH: begin
            op_valid = 1'b1;
            if (op_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_comb begin
      op.kind   = kind_ff;
      op.bucket = OP_CELL_W'(cell_clamp);
      op.per    = OP_PER_W'(per_ff);
      op.key    = key_ff;
   end

   always_ff @(posedge clock) begin
      gcols_ff <= gcols_in;
      grows_ff <= grows_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      cells_ff <= cells_in;
      cell_ff  <= cell_in;
      per_ff   <= per_in;
      key_ff   <= key_in;
      kind_ff  <= kind_in;
      if (reset) begin
         state_ff <= FS_IDLE;
         dirty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end
endmodule

// File: sv/gbk_back.sv
// back part: sorted per-cell insertion, drain walk, frame clearing
// depends on gbk_pkg and gbk_ram
module gbk_back import gbk_pkg::*; #(
   parameter int MAX_KEYPOINTS = 4096,
   parameter int MAX_CELLS     = 1024,
   parameter int MAX_PER_CELL  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        op_valid,
   output logic        op_ready,
   input  gbk_op_type  op,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // kept_index, zero fill
   output logic [1:0]  rsp_tuser,  // index_valid, dropped
   output logic        rsp_tlast
);
   localparam int CELL_W = MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1;
   localparam int CPOS_W = $clog2(MAX_CELLS + 1);
   localparam int CNT_W  = $clog2(MAX_PER_CELL + 1);
   localparam int ENT_D  = MAX_CELLS * MAX_PER_CELL;
   localparam int ENT_AW = ENT_D > 1 ? $clog2(ENT_D) : 1;
   localparam int ARR_W  = $clog2(MAX_KEYPOINTS + 1);

   back_state_type     state_ff, state_in;
   logic [ARR_W-1:0]   arr_ff, arr_in;
   logic               ovf_ff, ovf_in;
   logic [CPOS_W-1:0]  dc_ff, dc_in;
   logic [CNT_W-1:0]   ds_ff, ds_in;
   logic               second_ff, second_in;
   logic [IDX_W-1:0]   hold_ff, hold_in;
   logic [CELL_W-1:0]  cell_ff, cell_in, clr_ff, clr_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   per_ff, per_in, n_ff, n_in, j_ff, j_in;
   logic [ENT_AW-1:0]  base_ff, base_in;
   logic               em_valid_ff, em_valid_in, em_last_ff, em_last_in;
   logic [IDX_W-1:0]   em_idx_ff, em_idx_in;
   logic               rv_ff, rv_in, rval_ff, rval_in, rlast_ff, rlast_in;
   logic               rdrop_ff, rdrop_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;

   logic               c_we;
   logic [CELL_W-1:0]  c_waddr, c_raddr;
   logic [CNT_W-1:0]   c_wdata, c_rdata;
   logic               e_we;
   logic [ENT_AW-1:0]  e_waddr, e_raddr;
   logic [ENT_W-1:0]   e_wdata, e_rdata;
   logic [ARR_W+IDX_W-1:0] arr_ext;

   gbk_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_counts (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );
   gbk_ram #(.WIDTH(ENT_W), .DEPTH(ENT_D)) u_entries (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );

   always_comb begin
      arr_ext     = {{IDX_W{1'b0}}, arr_ff};
      state_in    = state_ff;
      arr_in      = arr_ff;
      ovf_in      = ovf_ff;
      dc_in       = dc_ff;
      ds_in       = ds_ff;
      second_in   = second_ff;
      hold_in     = hold_ff;
      cell_in     = cell_ff;
      clr_in      = clr_ff;
      key_in      = key_ff;
      per_in      = per_ff;
      n_in        = n_ff;
      j_in        = j_ff;
      base_in     = base_ff;
      em_valid_in = em_valid_ff;
      em_last_in  = em_last_ff;
      em_idx_in   = em_idx_ff;
      rv_in       = rv_ff && !rsp_tready;
      rval_in     = rval_ff;
      rlast_in    = rlast_ff;
      rdrop_in    = rdrop_ff;
      ridx_in     = ridx_ff;
      op_ready    = 1'b0;
      c_we        = 1'b0;
      c_waddr     = cell_ff;
      c_wdata     = '0;
      c_raddr     = CELL_W'(dc_ff);
      e_we        = 1'b0;
      e_waddr     = base_ff + ENT_AW'(j_ff);
      e_wdata     = e_rdata;
      e_raddr     = base_ff + ENT_AW'(j_ff) - ENT_AW'(1);
      case (state_ff)
         BS_CLEAR: begin
            c_we    = 1'b1;
            c_waddr = clr_ff;
            c_wdata = '0;
            if (clr_ff == CELL_W'(MAX_CELLS - 1)) begin
               state_in = BS_IDLE;
            end else begin
               clr_in = clr_ff + CELL_W'(1);
            end
         end
         BS_IDLE: begin
            op_ready = 1'b1;
            c_raddr  = CELL_W'(op.bucket);
            if (op_valid) begin
               if (op.kind == KIND_DRAIN) begin
                  second_in = 1'b0;
                  state_in  = BS_D_RD;
               end else if (arr_ff >= ARR_W'(MAX_KEYPOINTS)) begin
                  ovf_in = 1'b1;
               end else begin
                  cell_in  = CELL_W'(op.bucket);
                  key_in   = op.key;
                  per_in   = CNT_W'(op.per);
                  base_in  = ENT_AW'(ENT_AW'(op.bucket) * ENT_AW'(MAX_PER_CELL));
                  state_in = BS_L_CNT;
               end
            end
         end
         BS_L_CNT: begin
            // a list longer than the current share is cut here
            n_in     = (c_rdata > per_ff) ? per_ff : c_rdata;
            j_in     = (c_rdata > per_ff) ? per_ff : c_rdata;
            state_in = BS_L_SCAN;
         end
         BS_L_SCAN: begin
            state_in = (j_ff == '0) ? BS_L_DONE : BS_L_CMP;
         end
         BS_L_CMP: begin
            if (e_rdata[KEY_W-1:0] >= key_ff) begin
               state_in = BS_L_DONE;
            end else begin
               e_we     = j_ff < per_ff;
               j_in     = j_ff - CNT_W'(1);
               state_in = BS_L_SCAN;
            end
         end
         BS_L_DONE: begin
            c_we    = 1'b1;
            c_wdata = n_ff;
            if (j_ff < per_ff) begin
               e_we    = 1'b1;
               e_wdata = {arr_ext[IDX_W-1:0], key_ff};
               c_wdata = (n_ff == per_ff) ? n_ff : n_ff + CNT_W'(1);
            end
            arr_in   = arr_ff + ARR_W'(1);
            state_in = BS_IDLE;
         end
         BS_D_RD: begin
            if (dc_ff == CPOS_W'(MAX_CELLS)) begin
               em_valid_in = second_ff;
               em_idx_in   = second_ff ? hold_ff : '0;
               em_last_in  = 1'b1;
               state_in    = BS_EMIT;
            end else begin
               state_in = BS_D_CHK;
            end
         end
         BS_D_CHK: begin
            e_raddr = ENT_AW'(ENT_AW'(dc_ff) * ENT_AW'(MAX_PER_CELL)) + ENT_AW'(ds_ff);
            if (ds_ff < c_rdata) begin
               if (second_ff) begin
                  em_valid_in = 1'b1;
                  em_idx_in   = hold_ff;
                  em_last_in  = 1'b0;
                  state_in    = BS_EMIT;
               end else begin
                  state_in = BS_D_ENT;
               end
            end else begin
               dc_in    = dc_ff + CPOS_W'(1);
               ds_in    = '0;
               state_in = BS_D_RD;
            end
         end
         BS_D_ENT: begin
            hold_in   = e_rdata[ENT_W-1:KEY_W];
            ds_in     = ds_ff + CNT_W'(1);
            second_in = 1'b1;
            state_in  = BS_D_RD;
         end
         BS_EMIT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               ridx_in  = em_idx_ff;
               rval_in  = em_valid_ff;
               rlast_in = em_last_ff;
               rdrop_in = ovf_ff;
               if (em_last_ff) begin
                  arr_in   = '0;
                  ovf_in   = 1'b0;
                  dc_in    = '0;
                  ds_in    = '0;
                  clr_in   = '0;
                  state_in = BS_CLEAR;
               end else begin
                  state_in = BS_IDLE;
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      second_ff   <= second_in;
      hold_ff     <= hold_in;
      cell_ff     <= cell_in;
      key_ff      <= key_in;
      per_ff      <= per_in;
      n_ff        <= n_in;
      j_ff        <= j_in;
      base_ff     <= base_in;
      em_valid_ff <= em_valid_in;
      em_last_ff  <= em_last_in;
      em_idx_ff   <= em_idx_in;
      rval_ff     <= rval_in;
      rlast_ff    <= rlast_in;
      rdrop_ff    <= rdrop_in;
      ridx_ff     <= ridx_in;
      if (reset) begin
         state_ff <= BS_CLEAR;
         clr_ff   <= '0;
         arr_ff   <= '0;
         ovf_ff   <= 1'b0;
         dc_ff    <= '0;
         ds_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         arr_ff   <= arr_in;
         ovf_ff   <= ovf_in;
         dc_ff    <= dc_in;
         ds_ff    <= ds_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {{(16 - IDX_W){1'b0}}, ridx_ff};
   assign rsp_tuser  = {rdrop_ff, rval_ff};
   assign rsp_tlast  = rlast_ff;
endmodule

// File: sv/grid_bucketed_top_k_keypoint_select_core.sv
// top level of the grid bucketed top-k keypoint selector
// depends on gbk_pkg, gbk_front, gbk_queue, gbk_back
//
// usage
//  req channel: one beat per keypoint (tuser = 0) or per drain request
//    (tuser = 1). loads give no response; each drain gives one rsp beat
//  rsp channel: kept index, index_valid, dropped flag; tlast marks the
//    final beat of a frame, after which all per-frame state is cleared
//  csr port: geometry and target writes while the block is idle; a write
//    makes the front recompute the grid, with req_tready low meanwhile
//  loads: the front takes one load at a time, through two 14-bit
//    shift-subtract dividers, then a cell multiply, before the next accept;
//    the back reads the cell count, moves weaker entries down one place and
//    stops on an entry at least as strong (one entry ram access per step)
//  a drain passes the front and the queue; the back then walks the cells in
//    order, reading each count and then the entries, and looks one kept
//    entry ahead so that it can mark the last beat of the frame
//  reset: grid is recomputed and the count ram is swept to zero; the same
//    sweep follows the final beat of each frame
//  stall: a 2-deep op queue parts front and back, and a result register
//    holds one beat, so loads keep flowing while rsp_tready is low until
//    the back needs to emit the next drain result
module grid_bucketed_top_k_keypoint_select_core import gbk_pkg::*; #(
   parameter int MAX_KEYPOINTS = 4096,
   parameter int MAX_CELLS     = 1024,
   parameter int MAX_PER_CELL  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,  // x_pos, y_pos, strength
   input  logic             req_tuser,  // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,  // kept_index, zero fill
   output logic [1:0]       rsp_tuser,  // index_valid, dropped
   output logic             rsp_tlast,  // last_of_frame
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);
   logic [DIM_W-1:0] img_w_ff, img_w_in, img_h_ff, img_h_in, target_ff, target_in;
   logic [CS_W-1:0]  cs_ff, cs_in;

   // front to queue and queue to back
   logic             f_valid, f_ready, b_valid, b_ready;
   gbk_op_type       f_op, b_op;
   logic [OP_W-1:0]  b_bits;

   // config registers
   always_comb begin
      img_w_in  = img_w_ff;
      img_h_in  = img_h_ff;
      cs_in     = cs_ff;
      target_in = target_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     img_w_in  = csr_wdata;
            CSR_IMAGE_HEIGHT:    img_h_in  = csr_wdata;
            CSR_CELL_SIZE:       cs_in     = csr_wdata[CS_W-1:0];
            CSR_TARGET_FEATURES: target_in = csr_wdata;
            default:             img_w_in  = img_w_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= DIM_W'(640);
         img_h_ff  <= DIM_W'(480);
         cs_ff     <= CS_W'(32);
         target_ff <= DIM_W'(1000);
      end else begin
         img_w_ff  <= img_w_in;
         img_h_ff  <= img_h_in;
         cs_ff     <= cs_in;
         target_ff <= target_in;
      end
   end

   gbk_front #(.MAX_CELLS(MAX_CELLS), .MAX_PER_CELL(MAX_PER_CELL)) u_front (
      .clock(clock), .reset(reset),
      .image_width(img_w_ff), .image_height(img_h_ff), .cell_size(cs_ff),
      .target_features(target_ff), .csr_we(csr_we),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
   );

   gbk_queue #(.WIDTH(OP_W), .DEPTH(2)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_op),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_bits)
   );

   assign b_op = gbk_op_type'(b_bits);

   gbk_back #(
      .MAX_KEYPOINTS(MAX_KEYPOINTS), .MAX_CELLS(MAX_CELLS), .MAX_PER_CELL(MAX_PER_CELL)
   ) u_back (
      .clock(clock), .reset(reset),
      .op_valid(b_valid), .op_ready(b_ready), .op(b_op),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // an empty drain result always closes the frame and carries a zero index
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata[11:0] == 12'd0)
      else $error("empty drain result not marked last or index nonzero");

   // grid geometry is rebuilt after reset before any beat is taken
   a_reset_geom: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted before geometry recompute");
endmodule

// File: test/grid_bucketed_top_k_keypoint_select_core_test.sv
// self-checking bench for the grid bucketed top-k keypoint selector
// depends on gbk_pkg and grid_bucketed_top_k_keypoint_select_core
`timescale 1ns / 100ps

class kept_index_board;
   localparam int NCELL = 1024;
   localparam int NPER  = 8;
   localparam int NKP   = 4096;

   // own copy of block state and registers
   bit [12:0] img_w, img_h, tgt;
   bit [10:0] csize;
   bit [11:0] slot_idx [NCELL*NPER];
   bit [31:0] slot_key [NCELL*NPER];
   int unsigned cnt [NCELL];
   int unsigned arrivals;
   bit overflow;
   int unsigned dcell, dslot;
   // expectations enter at the front and leave at the back
   bit [15:0] exp_index [$];
   bit exp_valid [$];
   bit exp_last [$];
   bit exp_drop [$];
   int errors;

   function new();
      img_w = 640; img_h = 480; csize = 32; tgt = 1000;
      errors = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      foreach (cnt[i]) cnt[i] = 0;
      arrivals = 0; overflow = 0; dcell = 0; dslot = 0;
   endfunction

   function void set_reg(int idx, bit [12:0] v);
      case (idx)
         gbk_pkg::CSR_IMAGE_WIDTH:     img_w = v;
         gbk_pkg::CSR_IMAGE_HEIGHT:    img_h = v;
         gbk_pkg::CSR_CELL_SIZE:       csize = v[10:0];
         gbk_pkg::CSR_TARGET_FEATURES: tgt = v;
         default: ;
      endcase
   endfunction

   function bit find_next(inout int unsigned c, inout int unsigned s);
      while (c < NCELL) begin
         if (s < cnt[c]) return 1;
         c++;
         s = 0;
      end
      return 0;
   endfunction

   function void place_point(bit [15:0] x, bit [15:0] y, bit [31:0] st);
      int unsigned cs, w, h, cols, rows, per, gx, gy, bucket, base, n, pos;
      bit [31:0] key;
      cs = (csize == 0) ? 1 : csize;
      w = (img_w == 0) ? 1 : img_w;
      h = (img_h == 0) ? 1 : img_h;
      cols = (w + cs - 1) / cs;
      rows = (h + cs - 1) / cs;
      per = tgt / (cols * rows);
      if (arrivals >= NKP) begin
         overflow = 1;
         return;
      end
      if (per == 0) per = 1;
      if (per > NPER) per = NPER;
      gx = x / (16 * cs);
      if (gx > cols - 1) gx = cols - 1;
      gy = y / (16 * cs);
      if (gy > rows - 1) gy = rows - 1;
      bucket = gy * cols + gx;
      if (bucket >= NCELL) bucket = NCELL - 1;
      base = bucket * NPER;
      n = cnt[bucket];
      if (n > per) n = per;
      key = st ^ 32'h8000_0000;
      pos = 0;
      while (pos < n && slot_key[base+pos] >= key) pos++;
      if (pos < per) begin
         if (n == per) n--;
         for (int k = n; k > pos; k--) begin
            slot_idx[base+k] = slot_idx[base+k-1];
            slot_key[base+k] = slot_key[base+k-1];
         end
         slot_idx[base+pos] = arrivals[11:0];
         slot_key[base+pos] = key;
         n++;
      end
      cnt[bucket] = n;
      arrivals++;
   endfunction

   // note one accepted request beat
   function void note_request(bit kind, bit [15:0] x, bit [15:0] y, bit [31:0] st);
      int unsigned c, s;
      if (kind == gbk_pkg::KIND_LOAD) begin
         place_point(x, y, st);
         return;
      end
      exp_drop.push_front(overflow);
      c = dcell; s = dslot;
      if (!find_next(c, s)) begin
         exp_index.push_front(16'd0); exp_valid.push_front(1'b0);
         exp_last.push_front(1'b1);
         clear_frame();
         return;
      end
      exp_index.push_front({4'd0, slot_idx[c*NPER+s]});
      exp_valid.push_front(1'b1);
      s++;
      if (find_next(c, s)) begin
         dcell = c; dslot = s;
         exp_last.push_front(1'b0);
      end else begin
         exp_last.push_front(1'b1);
         clear_frame();
      end
   endfunction

   // compare one accepted response beat with the oldest expectation
   function void check_response(bit [15:0] idx, bit valid, bit last, bit drop);
      bit [15:0] ei;
      bit ev, el, ed;
      if (exp_index.size() == 0) begin
         $display("%0t: unexpected rsp beat index=%0d valid=%0b last=%0b dropped=%0b",
                  $time, idx, valid, last, drop);
         errors++;
         return;
      end
      ei = exp_index.pop_back(); ev = exp_valid.pop_back();
      el = exp_last.pop_back(); ed = exp_drop.pop_back();
      if (ei !== idx) begin
         $display("%0t: kept_index expected %0d actual %0d", $time, ei, idx);
         errors++;
      end
      if (ev !== valid) begin
         $display("%0t: index_valid expected %0b actual %0b", $time, ev, valid);
         errors++;
      end
      if (el !== last) begin
         $display("%0t: last_of_frame expected %0b actual %0b", $time, el, last);
         errors++;
      end
      if (ed !== drop) begin
         $display("%0t: dropped expected %0b actual %0b", $time, ed, drop);
         errors++;
      end
   endfunction

   function int pending();
      return exp_index.size();
   endfunction
endclass

module grid_bucketed_top_k_keypoint_select_core_test;
   import gbk_pkg::*;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [63:0]      req_tdata = '0;
   logic             req_tuser = 0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [15:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_we = 0;
   logic [1:0]       csr_index = '0;
   logic [DIM_W-1:0] csr_wdata = '0;

   kept_index_board board = new();

   // receiver stall control; hold_off forces a long stall from the receiver side
   bit hold_off = 0;
   bit burst_mode = 1;

   grid_bucketed_top_k_keypoint_select_core u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
      end
   end

   // receiver: stall pattern of its own, quiet stretches, and one long hold-off
   always @(negedge clock) begin
      if (hold_off)
         rsp_tready <= 0;
      else if (burst_mode)
         rsp_tready <= ($urandom_range(0, 3) != 0);
      else
         rsp_tready <= 1;
   end

   initial begin
      forever begin
         repeat ($urandom_range(50, 300)) @(negedge clock);
         burst_mode = ~burst_mode;
      end
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(bit kind, bit [15:0] x, bit [15:0] y, bit [31:0] st,
                            bit gap_ok);
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {st, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (gap_ok && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_load(bit [15:0] x, bit [15:0] y, bit [31:0] st);
      send_beat(KIND_LOAD, x, y, st, 1);
   endtask

   task automatic send_drain();
      send_beat(KIND_DRAIN, 16'($urandom), 16'($urandom), $urandom, 1);
   endtask

   task automatic end_of_phase();
      req_tvalid <= 0;
      while (board.pending() != 0) @(negedge clock);
      // the count ram sweep after a frame's final beat may still be running
      repeat (2200) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [12:0] v);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      board.set_reg(idx, v);
   endtask

   // drain at least until the frame's last beat has been predicted
   task automatic drain_frame();
      int left;
      left = 0;
      for (int c = 0; c < 1024; c++) left += board.cnt[c];
      for (int i = 0; i <= left; i++) send_drain();
   endtask

   task automatic random_frame(int n, int max_xy);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: send_load(16'($urandom), 16'($urandom), $urandom);
            1: send_load(16'($urandom_range(0, max_xy)), 16'($urandom_range(0, max_xy)),
                         32'($urandom_range(0, 3)));
            9: send_drain();  // load during drain
            default: send_load(16'($urandom_range(0, max_xy)),
                               16'($urandom_range(0, max_xy)), $urandom);
         endcase
      end
      drain_frame();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 0;
      repeat (1100) @(negedge clock);

      // directed, reset geometry: field extremes, ties, full cell, empty drain
      send_drain();                                   // empty drain
      send_load(16'h0000, 16'h0000, 32'h7fff_ffff);
      send_load(16'hffff, 16'hffff, 32'h8000_0000);
      send_load(16'h0000, 16'h0000, 32'h7fff_ffff);   // tie, earlier wins
      send_load(16'h0001, 16'h0002, 32'h0000_0000);
      send_load(16'h01ff, 16'h01ff, 32'hffff_ffff);
      send_drain();
      send_load(16'haaaa, 16'h5555, 32'h5555_aaaa);   // load during drain
      drain_frame();
      end_of_phase();

      // one cell, per_cell 1: evict only when strictly stronger
      write_reg(CSR_IMAGE_WIDTH, 13'd1);
      write_reg(CSR_IMAGE_HEIGHT, 13'd1);
      write_reg(CSR_CELL_SIZE, 13'd1024);
      write_reg(CSR_TARGET_FEATURES, 13'd0);
      send_load(16'd5, 16'd5, 32'd10);
      send_load(16'd6, 16'd6, 32'd10);
      send_load(16'd7, 16'd7, 32'd11);
      send_load(16'd8, 16'd8, -32'sd1);
      drain_frame();
      end_of_phase();

      // zero geometry, large target; too many cells clamps to the last cell
      write_reg(CSR_IMAGE_WIDTH, 13'd0);
      write_reg(CSR_IMAGE_HEIGHT, 13'd0);
      write_reg(CSR_CELL_SIZE, 13'd0);
      write_reg(CSR_TARGET_FEATURES, 13'd8191);
      random_frame(20, 65535);
      end_of_phase();
      write_reg(CSR_IMAGE_WIDTH, 13'd4096);
      write_reg(CSR_IMAGE_HEIGHT, 13'd4096);
      write_reg(CSR_CELL_SIZE, 13'd1);
      write_reg(CSR_TARGET_FEATURES, 13'd4096);
      random_frame(15, 65535);
      end_of_phase();

      // shrunk share: fill one cell with the larger share, then lower the
      // target mid frame so the next insertion cuts the list
      write_reg(CSR_IMAGE_WIDTH, 13'd64);
      write_reg(CSR_IMAGE_HEIGHT, 13'd64);
      write_reg(CSR_CELL_SIZE, 13'd32);
      write_reg(CSR_TARGET_FEATURES, 13'd40);
      for (int i = 0; i < 12; i++) send_load(16'd16, 16'd16, $urandom);
      end_of_phase();
      write_reg(CSR_TARGET_FEATURES, 13'd8);
      for (int i = 0; i < 6; i++) send_load(16'd16, 16'd16, $urandom);
      drain_frame();
      end_of_phase();

      // random frames; receiver holds off during one to fill the block
      for (int f = 0; f < 5; f++) begin
         write_reg(CSR_IMAGE_WIDTH, 13'($urandom_range(1, 8191)));
         write_reg(CSR_IMAGE_HEIGHT, 13'($urandom_range(1, 8191)));
         write_reg(CSR_CELL_SIZE, 13'($urandom_range(1, 2047)));
         write_reg(CSR_TARGET_FEATURES, 13'($urandom_range(0, 8191)));
         if (f == 2) hold_off = 1;
         fork
            random_frame(40, 4095);
            begin
               if (f == 2) begin
                  repeat (1500) @(negedge clock);
                  hold_off = 0;
               end
            end
         join
         end_of_phase();
      end

      // tight grid, many keypoints per cell, random frames on one fixed config
      write_reg(CSR_IMAGE_WIDTH, 13'd48);
      write_reg(CSR_IMAGE_HEIGHT, 13'd48);
      write_reg(CSR_CELL_SIZE, 13'd16);
      write_reg(CSR_TARGET_FEATURES, 13'd30);
      for (int f = 0; f < 2; f++) begin
         random_frame(45, 1023);
         end_of_phase();
      end

      end_of_phase();
      if (board.errors == 0 && board.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// File: filelist.f
sv/gbk_pkg.sv
sv/gbk_ram.sv
sv/gbk_div.sv
sv/gbk_queue.sv
sv/gbk_front.sv
sv/gbk_back.sv
sv/grid_bucketed_top_k_keypoint_select_core.sv
test/grid_bucketed_top_k_keypoint_select_core_test.sv
